// ----- rtl/gbba_pkg.sv -----
// ----------------------------------------------------------------------------
// gbba_pkg
// Shared types and codes for the grouped bitmap block allocator.
// ----------------------------------------------------------------------------
package gbba_pkg;

    localparam int BN_W    = 14;  // block number and count field width
    localparam int WORD_W  = 32;  // bitmap memory word width
    localparam int WORD_BW = 5;   // bit index width inside one word

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NOSPACE      = 2'd1;
    localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [1:0] ST_RANGE        = 2'd3;

    typedef struct packed {
        logic            cmd;
        logic [BN_W-1:0] block_number;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [BN_W-1:0] block_number_out;
        logic [BN_W-1:0] free_total;
    } t_rsp;

endpackage

// ----- rtl/gbba_ram.sv -----
// ----------------------------------------------------------------------------
// gbba_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gbba_zfind.sv -----
// ----------------------------------------------------------------------------
// gbba_zfind
// Lowest clear bit finder over one bitmap word.
// ----------------------------------------------------------------------------
module gbba_zfind (
    input  logic [gbba_pkg::WORD_W-1:0]  i_word,
    output logic                         o_found,
    output logic [gbba_pkg::WORD_BW-1:0] o_idx
);

    import gbba_pkg::*;

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_found = 1'b1;
                o_idx   = WORD_BW'(i);
            end
        end
    end

endmodule

// ----- rtl/grouped_bitmap_block_allocator.sv -----
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator
// Bitmap block allocator split into groups with per-group and total free counts.
// ----------------------------------------------------------------------------
// Allocate: scans the group free counts for the first group with free blocks,
//   then that group's bitmap words for the first clear bit (one read a cycle).
// Free: the group index comes from a subtract-per-cycle loop, then the word
//   is read, checked and written back. Range and empty checks skip the scans.
// One transaction in flight.
// Reset: a clearing pass over GROUPS*ceil(BLOCKS_PER_GROUP/32) words (256 at
//   the defaults) zeroes the bitmap and loads the group counts; input stalls.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator #(
    parameter int GROUPS           = 8,
    parameter int BLOCKS_PER_GROUP = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gbba_pkg::t_req   i_in_data,
    // response channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output gbba_pkg::t_rsp   o_out_data,
    // configuration: first_data_block
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata
);

    import gbba_pkg::*;

    // ------------------------------------------------------------------
    // Derived geometry. Each group owns WPG whole bitmap words; bits of the
    // last word beyond the group's end are padding and read as used.
    // ------------------------------------------------------------------
    localparam int TOTAL     = GROUPS * BLOCKS_PER_GROUP;
    localparam int TBW       = $clog2(TOTAL + 1);
    localparam int XW        = ((TBW > BN_W) ? TBW : BN_W) + 1;
    localparam int WPG       = (BLOCKS_PER_GROUP + WORD_W - 1) / WORD_W;
    localparam int MAP_DEPTH = GROUPS * WPG;
    localparam int MAW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int WW        = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int OW        = $clog2(BLOCKS_PER_GROUP);
    localparam int CW        = $clog2(BLOCKS_PER_GROUP + 1);
    localparam int LAST_BITS = BLOCKS_PER_GROUP - (WPG - 1) * WORD_W;
    localparam logic [WORD_W-1:0] PAD_MASK =
        (LAST_BITS >= WORD_W) ? '0 : ~((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    localparam logic [2:0] S_CLR   = 3'd0;  // post-reset clearing pass
    localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for a transaction
    localparam logic [2:0] S_GSCAN = 3'd2;  // scan group free counts
    localparam logic [2:0] S_WSCAN = 3'd3;  // scan bitmap words of one group
    localparam logic [2:0] S_FDIV  = 3'd4;  // split free block into group/offset
    localparam logic [2:0] S_FRD   = 3'd5;  // read bitmap word and group count
    localparam logic [2:0] S_FCHK  = 3'd6;  // check bit, write back
    localparam logic [2:0] S_DONE  = 3'd7;  // hand result to output register

    // control state
    logic [2:0]     r_state,   n_state;
    logic [MAW-1:0] r_clr,     n_clr;
    logic           r_fdb,     n_fdb;
    logic [TBW-1:0] r_total,   n_total;
    logic           r_pend,    n_pend;
    logic           r_out_vld, n_out_vld;
    // working registers
    logic [GW-1:0]  r_g,       n_g;
    logic [GW-1:0]  r_chk,     n_chk;
    logic [GW-1:0]  r_gsel,    n_gsel;
    logic [CW-1:0]  r_gcnt,    n_gcnt;
    logic [WW-1:0]  r_w,       n_w;
    logic [WW-1:0]  r_wchk,    n_wchk;
    logic [MAW-1:0] r_base,    n_base;
    logic [TBW-1:0] r_blkbase, n_blkbase;
    logic [TBW-1:0] r_rem,     n_rem;
    logic [4:0]     r_bit,     n_bit;
    logic [1:0]     r_st,      n_st;
    logic [BN_W-1:0] r_blk,    n_blk;
    t_rsp           r_out,     n_out;

    // memory ports
    logic              map_we;
    logic [MAW-1:0]    map_waddr;
    logic [WORD_W-1:0] map_wdata;
    logic [MAW-1:0]    map_raddr;
    logic [WORD_W-1:0] map_rdata;
    logic              cnt_we;
    logic [GW-1:0]     cnt_waddr;
    logic [CW-1:0]     cnt_wdata;
    logic [CW-1:0]     cnt_rdata;

    // lowest clear bit of the word under check (padding forced to used)
    logic [WORD_W-1:0]  scan_word;
    logic               z_found;
    logic [WORD_BW-1:0] z_idx;

    // usage bitmap, one bit per block, 32 blocks per word
    gbba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // per-group free counts
    gbba_ram #(
        .WIDTH (CW),
        .DEPTH (GROUPS)
    ) u_cnt (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_g),
        .o_rdata (cnt_rdata)
    );

    gbba_zfind u_zfind (
        .i_word  (scan_word),
        .o_found (z_found),
        .o_idx   (z_idx)
    );

    assign scan_word = (r_wchk == WW'(WPG - 1)) ? (map_rdata | PAD_MASK) : map_rdata;

    // Bitmap reads always come from base + issue index; the write address
    // uses the index of the word whose data is in hand, except in the clearing pass.
    assign map_raddr = r_base + MAW'(r_w);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        logic [XW-1:0]  rel;
        logic [OW-1:0]  off;
        logic [TBW:0]   blk_full;

        n_state   = r_state;
        n_clr     = r_clr;
        n_fdb     = r_fdb;
        n_total   = r_total;
        n_pend    = r_pend;
        n_out_vld = r_out_vld;
        n_g       = r_g;
        n_chk     = r_chk;
        n_gsel    = r_gsel;
        n_gcnt    = r_gcnt;
        n_w       = r_w;
        n_wchk    = r_wchk;
        n_base    = r_base;
        n_blkbase = r_blkbase;
        n_rem     = r_rem;
        n_bit     = r_bit;
        n_st      = r_st;
        n_blk     = r_blk;
        n_out     = r_out;

        map_we    = 1'b0;
        map_waddr = r_base + MAW'(r_wchk);
        map_wdata = map_rdata;
        cnt_we    = 1'b0;
        cnt_waddr = r_gsel;
        cnt_wdata = r_gcnt;

        rel      = XW'(i_in_data.block_number) - XW'(r_fdb);
        off      = OW'(r_rem);
        blk_full = (TBW + 1)'(r_blkbase) + (TBW + 1)'({r_wchk, 5'b0})
                 + (TBW + 1)'(z_idx) + (TBW + 1)'(r_fdb);

        if (i_cfg_we) begin
            n_fdb = i_cfg_wdata;
        end

        // output register frees up when the consumer takes it
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                map_wdata = '0;
                cnt_we    = (MAW'(r_clr) < MAW'(GROUPS)) || (GROUPS > MAP_DEPTH - 1);
                cnt_waddr = GW'(r_clr);
                cnt_wdata = CW'(BLOCKS_PER_GROUP);
                n_clr     = r_clr + MAW'(1);
                if (r_clr == MAW'(MAP_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_pend = 1'b0;
                n_g    = '0;
                n_w    = '0;
                n_wchk = '0;
                n_blk  = '0;
                if (i_in_valid) begin
                    if (i_in_data.cmd == CMD_ALLOC) begin
                        if (r_total == '0) begin
                            n_st    = ST_NOSPACE;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_GSCAN;
                        end
                    end else begin
                        if ((i_in_data.block_number == '0 && r_fdb) ||
                            (rel >= XW'(TOTAL))) begin
                            n_st    = ST_RANGE;
                            n_state = S_DONE;
                        end else begin
                            n_rem   = TBW'(rel);
                            n_state = S_FDIV;
                        end
                    end
                end
            end
            S_GSCAN: begin
                // one count read issued per cycle, checked in the following cycle
                n_g    = r_g + GW'(1);
                n_chk  = r_g;
                n_pend = 1'b1;
                if (r_pend) begin
                    if (cnt_rdata != '0) begin
                        n_gsel    = r_chk;
                        n_gcnt    = cnt_rdata;
                        n_base    = MAW'(r_chk * WPG);
                        n_blkbase = TBW'(r_chk * BLOCKS_PER_GROUP);
                        n_w       = '0;
                        n_pend    = 1'b0;
                        n_state   = S_WSCAN;
                    end else if (r_chk == GW'(GROUPS - 1)) begin
                        n_st    = ST_NOSPACE;
                        n_state = S_DONE;
                    end
                end
            end
            S_WSCAN: begin
                n_w    = r_w + WW'(1);
                n_wchk = r_w;
                n_pend = 1'b1;
                if (r_pend) begin
                    if (z_found) begin
                        map_we    = 1'b1;
                        map_wdata = map_rdata | (WORD_W'(1) << z_idx);
                        cnt_we    = 1'b1;
                        cnt_wdata = r_gcnt - CW'(1);
                        n_total   = r_total - TBW'(1);
                        n_blk     = BN_W'(blk_full);
                        n_st      = ST_OK;
                        n_state   = S_DONE;
                    end else if (r_wchk == WW'(WPG - 1)) begin
                        n_st    = ST_NOSPACE;
                        n_state = S_DONE;
                    end
                end
            end
            S_FDIV: begin
                if (r_rem >= TBW'(BLOCKS_PER_GROUP)) begin
                    n_rem = r_rem - TBW'(BLOCKS_PER_GROUP);
                    n_g   = r_g + GW'(1);
                end else begin
                    n_gsel  = r_g;
                    n_base  = MAW'(r_g * WPG) + MAW'(off >> WORD_BW);
                    n_bit   = 5'(off);
                    n_w     = '0;
                    n_wchk  = '0;
                    n_state = S_FRD;
                end
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (!map_rdata[r_bit]) begin
                    n_st = ST_ALREADY_FREE;
                end else begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata & ~(WORD_W'(1) << r_bit);
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rdata + CW'(1);
                    n_total   = r_total + TBW'(1);
                    n_st      = ST_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld              = 1'b1;
                    n_out.status           = r_st;
                    n_out.block_number_out = r_blk;
                    n_out.free_total       = BN_W'(r_total);
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_fdb     <= 1'b1;
            r_total   <= TBW'(TOTAL);
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_fdb     <= n_fdb;
            r_total   <= n_total;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g       <= n_g;
        r_chk     <= n_chk;
        r_gsel    <= n_gsel;
        r_gcnt    <= n_gcnt;
        r_w       <= n_w;
        r_wchk    <= n_wchk;
        r_base    <= n_base;
        r_blkbase <= n_blkbase;
        r_rem     <= n_rem;
        r_bit     <= n_bit;
        r_st      <= n_st;
        r_blk     <= n_blk;
        r_out     <= n_out;
    end

endmodule
